// File: hdl/rec_pkg.sv
// rec_pkg: types, constants and the byte-wise crc-32 step for the record envelope checker
// no dependencies; imported by the interfaces and every module of the block
package rec_pkg;

  localparam int unsigned HDR_BASE  = 37;
  localparam int unsigned UTC_SIZE  = 8;
  localparam int unsigned CRC_SIZE  = 4;
  localparam int unsigned MIN_TOTAL = HDR_BASE + CRC_SIZE;

  localparam logic [31:0] MAGIC_WORD    = 32'h4450_5246;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [15:0] EXP_VER_RESET = 16'd1;

  // byte offsets of the fixed header fields (offset of each field's last byte)
  localparam int unsigned POS_MAGIC_END  = 3;
  localparam int unsigned POS_VER_END    = 5;
  localparam int unsigned POS_TYPE_END   = 7;
  localparam int unsigned POS_SCHEMA_END = 11;
  localparam int unsigned POS_EPOCH_END  = 19;
  localparam int unsigned POS_VALUE_END  = 27;
  localparam int unsigned POS_LEN_END    = 31;
  localparam int unsigned POS_ORIGIN_END = 33;
  localparam int unsigned POS_OP_END     = 35;
  localparam int unsigned POS_UTC_TAG    = 36;
  localparam int unsigned POS_UTC_END    = HDR_BASE + UTC_SIZE - 1;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_LENGTH  = 4'd1,
    ST_MAGIC   = 4'd2,
    ST_VERSION = 4'd3,
    ST_TYPE    = 4'd4,
    ST_SCHEMA  = 4'd5,
    ST_EPOCH   = 4'd6,
    ST_VALUE   = 4'd7,
    ST_UTC_TAG = 4'd8,
    ST_CRC     = 4'd9
  } rec_status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } rec_kind_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         payload_byte;
    logic [3:0]         status;
    logic [15:0]        record_type;
    logic [31:0]        schema_version;
    logic [63:0]        storage_epoch;
    logic [63:0]        version_value;
    logic [15:0]        change_origin;
    logic [15:0]        change_operation;
    logic               utc_present;
    logic signed [63:0] utc_seconds;
    logic [31:0]        payload_length;
  } rec_result_t;

  // reflected crc-32, one byte per call
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hdl/rec_ifs.sv
// rec_ifs: valid/ready channel interfaces for record bytes, results and the config write
// depends on rec_pkg
interface rec_in_if import rec_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface rec_out_if import rec_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         payload_byte;
  logic [3:0]         status;
  logic [15:0]        record_type;
  logic [31:0]        schema_version;
  logic [63:0]        storage_epoch;
  logic [63:0]        version_value;
  logic [15:0]        change_origin;
  logic [15:0]        change_operation;
  logic               utc_present;
  logic signed [63:0] utc_seconds;
  logic [31:0]        payload_length;

  modport source (output valid, kind, payload_byte, status, record_type, schema_version,
                  storage_epoch, version_value, change_origin, change_operation,
                  utc_present, utc_seconds, payload_length, input ready);
  modport sink   (input valid, kind, payload_byte, status, record_type, schema_version,
                  storage_epoch, version_value, change_origin, change_operation,
                  utc_present, utc_seconds, payload_length, output ready);
endinterface

interface rec_cfg_if import rec_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hdl/rec_parser.sv
// rec_parser: per-byte header capture, checks, crc and summary build for one record
// depends on rec_pkg; feeds up to two results per item to rec_out_fifo
module rec_parser import rec_pkg::*; #(
  parameter int COUNT_WIDTH = 34
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic [1:0]        push_cnt,
  output rec_result_t       res0,
  output rec_result_t       res1
);

  localparam int TW = COUNT_WIDTH + 1;

  logic [15:0]            exp_ver_r;
  logic [COUNT_WIDTH-1:0] pos_r,    pos_nxt;
  logic [63:0]            shift_r,  shift_nxt;
  logic [31:0]            crc_r,    crc_nxt;
  logic [3:0]             err_r,    err_nxt;
  logic [15:0]            type_r,   type_nxt;
  logic [31:0]            schema_r, schema_nxt;
  logic [63:0]            epoch_r,  epoch_nxt;
  logic [63:0]            value_r,  value_nxt;
  logic [31:0]            len_r,    len_nxt;
  logic [15:0]            origin_r, origin_nxt;
  logic [15:0]            op_r,     op_nxt;
  logic                   utc_f_r,  utc_f_nxt;
  logic [63:0]            utc_v_r,  utc_v_nxt;
  logic [31:0]            crch_r,   crch_nxt;

  logic [COUNT_WIDTH-1:0] hdr;
  logic                   in_crc_field;
  logic                   emit;
  logic [TW-1:0]          total;
  logic [TW-1:0]          want;
  logic [3:0]             status;
  rec_result_t            pay;
  rec_result_t            summ;

  always_comb begin
    pos_nxt    = pos_r;
    shift_nxt  = shift_r;
    crc_nxt    = crc_r;
    err_nxt    = err_r;
    type_nxt   = type_r;
    schema_nxt = schema_r;
    epoch_nxt  = epoch_r;
    value_nxt  = value_r;
    len_nxt    = len_r;
    origin_nxt = origin_r;
    op_nxt     = op_r;
    utc_f_nxt  = utc_f_r;
    utc_v_nxt  = utc_v_r;
    crch_nxt   = crch_r;

    hdr = utc_f_r ? COUNT_WIDTH'(HDR_BASE + UTC_SIZE) : COUNT_WIDTH'(HDR_BASE);
    in_crc_field = (pos_r >= hdr) && (pos_r < hdr + COUNT_WIDTH'(CRC_SIZE));
    emit = accept && !in_crc_field && (pos_r >= hdr + COUNT_WIDTH'(CRC_SIZE));

    if (accept) begin
      shift_nxt = {shift_r[55:0], data_byte};

      if (pos_r == COUNT_WIDTH'(POS_MAGIC_END)) begin
        if (shift_nxt[31:0] != MAGIC_WORD && err_r == ST_OK) err_nxt = ST_MAGIC;
      end else if (pos_r == COUNT_WIDTH'(POS_VER_END)) begin
        if (shift_nxt[15:0] != exp_ver_r && err_r == ST_OK) err_nxt = ST_VERSION;
      end else if (pos_r == COUNT_WIDTH'(POS_TYPE_END)) begin
        type_nxt = shift_nxt[15:0];
        if (shift_nxt[15:0] == 16'd0 && err_r == ST_OK) err_nxt = ST_TYPE;
      end else if (pos_r == COUNT_WIDTH'(POS_SCHEMA_END)) begin
        schema_nxt = shift_nxt[31:0];
        if (shift_nxt[31:0] == 32'd0 && err_r == ST_OK) err_nxt = ST_SCHEMA;
      end else if (pos_r == COUNT_WIDTH'(POS_EPOCH_END)) begin
        epoch_nxt = shift_nxt;
        if (shift_nxt == 64'd0 && err_r == ST_OK) err_nxt = ST_EPOCH;
      end else if (pos_r == COUNT_WIDTH'(POS_VALUE_END)) begin
        value_nxt = shift_nxt;
        if (shift_nxt == 64'd0 && err_r == ST_OK) err_nxt = ST_VALUE;
      end else if (pos_r == COUNT_WIDTH'(POS_LEN_END)) begin
        len_nxt = shift_nxt[31:0];
      end else if (pos_r == COUNT_WIDTH'(POS_ORIGIN_END)) begin
        origin_nxt = shift_nxt[15:0];
      end else if (pos_r == COUNT_WIDTH'(POS_OP_END)) begin
        op_nxt = shift_nxt[15:0];
      end else if (pos_r == COUNT_WIDTH'(POS_UTC_TAG)) begin
        if (data_byte == 8'd1) begin
          utc_f_nxt = 1'b1;
        end else if (data_byte != 8'd0 && err_r == ST_OK) begin
          err_nxt = ST_UTC_TAG;
        end
      end else if (pos_r == COUNT_WIDTH'(POS_UTC_END) && utc_f_r) begin
        utc_v_nxt = shift_nxt;
      end

      // stored crc is captured, everything else runs through the crc
      if (in_crc_field) begin
        if (pos_r == hdr + COUNT_WIDTH'(CRC_SIZE - 1)) crch_nxt = shift_nxt[31:0];
      end else begin
        crc_nxt = crc_byte(crc_r, data_byte);
      end

      if (pos_r != {COUNT_WIDTH{1'b1}}) pos_nxt = pos_r + 1'b1;
    end

    total = {1'b0, pos_r} + 1'b1;
    want  = TW'(hdr) + TW'(CRC_SIZE) + TW'(len_nxt);
    if (total < TW'(MIN_TOTAL)) begin
      status = ST_LENGTH;
    end else if (err_nxt != ST_OK) begin
      status = err_nxt;
    end else if (total != want) begin
      status = ST_LENGTH;
    end else if ((crc_nxt ^ CRC_INIT) != crch_nxt) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end

    pay              = '0;
    pay.kind         = KIND_PAYLOAD;
    pay.payload_byte = data_byte;

    summ                  = '0;
    summ.kind             = KIND_SUMMARY;
    summ.status           = status;
    summ.record_type      = type_nxt;
    summ.schema_version   = schema_nxt;
    summ.storage_epoch    = epoch_nxt;
    summ.version_value    = value_nxt;
    summ.change_origin    = origin_nxt;
    summ.change_operation = op_nxt;
    summ.utc_present      = utc_f_nxt;
    summ.utc_seconds      = utc_f_nxt ? utc_v_nxt : 64'd0;
    summ.payload_length   = len_nxt;

    res0     = emit ? pay : summ;
    res1     = summ;
    push_cnt = {1'b0, emit} + {1'b0, accept && last_byte};

    // end of record: back to a clean slate
    if (accept && last_byte) begin
      pos_nxt    = '0;
      shift_nxt  = '0;
      crc_nxt    = CRC_INIT;
      err_nxt    = ST_OK;
      type_nxt   = '0;
      schema_nxt = '0;
      epoch_nxt  = '0;
      value_nxt  = '0;
      len_nxt    = '0;
      origin_nxt = '0;
      op_nxt     = '0;
      utc_f_nxt  = 1'b0;
      utc_v_nxt  = '0;
      crch_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ver_r <= EXP_VER_RESET;
      pos_r     <= '0;
      shift_r   <= '0;
      crc_r     <= CRC_INIT;
      err_r     <= ST_OK;
      type_r    <= '0;
      schema_r  <= '0;
      epoch_r   <= '0;
      value_r   <= '0;
      len_r     <= '0;
      origin_r  <= '0;
      op_r      <= '0;
      utc_f_r   <= 1'b0;
      utc_v_r   <= '0;
      crch_r    <= '0;
    end else begin
      if (cfg_we) exp_ver_r <= cfg_data;
      pos_r    <= pos_nxt;
      shift_r  <= shift_nxt;
      crc_r    <= crc_nxt;
      err_r    <= err_nxt;
      type_r   <= type_nxt;
      schema_r <= schema_nxt;
      epoch_r  <= epoch_nxt;
      value_r  <= value_nxt;
      len_r    <= len_nxt;
      origin_r <= origin_nxt;
      op_r     <= op_nxt;
      utc_f_r  <= utc_f_nxt;
      utc_v_r  <= utc_v_nxt;
      crch_r   <= crch_nxt;
    end
  end

endmodule

// File: hdl/rec_out_fifo.sv
// rec_out_fifo: four-entry result queue taking up to two results a cycle, one out a cycle
// depends on rec_pkg
module rec_out_fifo import rec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  push_cnt,
  input  rec_result_t push0,
  input  rec_result_t push1,
  output logic        has_room,
  output logic        head_valid,
  input  logic        head_ready,
  output rec_result_t head
);

  rec_result_t mem_r [4];
  logic [1:0]  wp_r, wp_nxt;
  logic [1:0]  rp_r, rp_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign has_room   = (cnt_r <= 3'd2);
  assign head_valid = (cnt_r != 3'd0);
  assign head       = mem_r[rp_r];
  assign pop        = head_valid && head_ready;

  always_comb begin
    wp_nxt  = wp_r + push_cnt;
    rp_nxt  = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push_cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wp_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wp_r + 2'd1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/record_envelope_checker.sv
// record_envelope_checker: top level joining the parser and the result queue
// depends on rec_pkg, rec_ifs, rec_parser and rec_out_fifo
//
// usage
//   in_chan carries one record byte per item with last_byte set on the final byte.
//   out_chan gives a payload item (kind 0) for every byte after the stored crc and,
//   on the final byte, a summary item (kind 1) with status and the header fields.
//   cfg_chan writes expected_version; it is always ready, and it is to be written only
//   while no record is in flight: the user is bound to this, the block does not enforce it.
//   one input item is taken per cycle while the queue has room; the byte is parsed,
//   checked and crc'd in the cycle it is taken, and its results are registered in a
//   four-entry queue before they appear on out_chan.
//   an item may cause two results (last payload byte plus summary); the queue drains
//   one a cycle while out_chan.ready is high, so a record keeps one byte per cycle
//   except that the summary is one extra item to drain.
//   in_chan.ready drops while the queue has fewer than two free entries, so a
//   stalled receiver holds the input back and nothing is lost.
//   reset clears the record state, sets expected_version to 1 and empties the queue;
//   after each summary the record state returns to reset for the next record.
module record_envelope_checker import rec_pkg::*; #(
  parameter int COUNT_WIDTH = 34
) (
  input  logic clk,
  input  logic rst_n,
  rec_in_if.sink    in_chan,
  rec_out_if.source out_chan,
  rec_cfg_if.sink   cfg_chan
);

  logic        room;
  logic        accept;
  logic [1:0]  push_cnt;
  rec_result_t res0;
  rec_result_t res1;
  rec_result_t head;

  assign in_chan.ready  = room;
  assign accept         = in_chan.valid && room;
  assign cfg_chan.ready = 1'b1;

  rec_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_chan.valid),
    .cfg_data  (cfg_chan.data),
    .accept    (accept),
    .data_byte (in_chan.data_byte),
    .last_byte (in_chan.last_byte),
    .push_cnt  (push_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  rec_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push0      (res0),
    .push1      (res1),
    .has_room   (room),
    .head_valid (out_chan.valid),
    .head_ready (out_chan.ready),
    .head       (head)
  );

  assign out_chan.kind             = head.kind;
  assign out_chan.payload_byte     = head.payload_byte;
  assign out_chan.status           = head.status;
  assign out_chan.record_type      = head.record_type;
  assign out_chan.schema_version   = head.schema_version;
  assign out_chan.storage_epoch    = head.storage_epoch;
  assign out_chan.version_value    = head.version_value;
  assign out_chan.change_origin    = head.change_origin;
  assign out_chan.change_operation = head.change_operation;
  assign out_chan.utc_present      = head.utc_present;
  assign out_chan.utc_seconds      = head.utc_seconds;
  assign out_chan.payload_length   = head.payload_length;

endmodule

// File: verif/record_envelope_checker_tb.sv
// record_envelope_checker_tb: self-checking bench for the record envelope checker
// drives whole records byte by byte and checks every payload and summary item
// against a byte-wise envelope parser; depends on rec_pkg, rec_ifs and the rtl
`timescale 1ns / 100ps

module record_envelope_checker_tb;
  import rec_pkg::*;

  localparam int COUNT_W     = 34;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int RANDOM_ITEMS = 450;

  // header as it sits on the wire, most significant byte first
  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] env_ver;
    logic [15:0] rtype;
    logic [31:0] schema;
    logic [63:0] epoch;
    logic [63:0] vval;
    logic [31:0] plen;
    logic [15:0] origin;
    logic [15:0] op;
    logic [7:0]  utc_tag;
    logic [63:0] utc_secs;
  } env_hdr_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rec_in_if  in_if ();
  rec_out_if out_if ();
  rec_cfg_if cfg_if ();

  record_envelope_checker #(.COUNT_WIDTH(COUNT_W)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #5 clk = ~clk;

  // parser state
  logic [COUNT_W-1:0] pos_cnt;
  logic [63:0]        shift_reg;
  logic [31:0]        crc_acc;
  rec_status_t        first_fault;
  logic [15:0]        type_seen;
  logic [31:0]        schema_seen;
  logic [63:0]        epoch_seen;
  logic [63:0]        value_seen;
  logic [31:0]        length_seen;
  logic [15:0]        origin_seen;
  logic [15:0]        op_seen;
  logic               utc_on;
  logic [63:0]        utc_secs_seen;
  logic [31:0]        crc_stored;
  logic [15:0]        exp_ver;

  rec_result_t envelope_results[$];
  logic [7:0]  rec_bytes[$];

  int          mismatches = 0;
  int          bytes_taken = 0;
  int          cycle_count = 0;
  int          tx_gap_odds = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          rx_burst = 0;
  bit          quiet = 1'b0;

  function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] d);
    logic [31:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ ({32{r[0] ^ d[k]}} & CRC_POLY);
    end
    return r;
  endfunction

  task automatic clear_envelope();
    pos_cnt       = '0;
    shift_reg     = '0;
    crc_acc       = CRC_INIT;
    first_fault   = ST_OK;
    type_seen     = '0;
    schema_seen   = '0;
    epoch_seen    = '0;
    value_seen    = '0;
    length_seen   = '0;
    origin_seen   = '0;
    op_seen       = '0;
    utc_on        = 1'b0;
    utc_secs_seen = '0;
    crc_stored    = '0;
  endtask

  task automatic flag_fault(input rec_status_t code);
    if (first_fault == ST_OK) first_fault = code;
  endtask

  // one accepted byte: update the envelope state and queue the items it causes
  task automatic parse_envelope_byte(input logic [7:0] b, input logic fin);
    logic [63:0] p;
    logic [63:0] hlen;
    logic [63:0] total;
    logic [63:0] want;
    rec_result_t r;
    rec_status_t st;
    p    = 64'(pos_cnt);
    hlen = utc_on ? 64'(HDR_BASE + UTC_SIZE) : 64'(HDR_BASE);
    shift_reg = {shift_reg[55:0], b};
    if (p == POS_MAGIC_END) begin
      if (shift_reg[31:0] != MAGIC_WORD) flag_fault(ST_MAGIC);
    end else if (p == POS_VER_END) begin
      if (shift_reg[15:0] != exp_ver) flag_fault(ST_VERSION);
    end else if (p == POS_TYPE_END) begin
      type_seen = shift_reg[15:0];
      if (type_seen == '0) flag_fault(ST_TYPE);
    end else if (p == POS_SCHEMA_END) begin
      schema_seen = shift_reg[31:0];
      if (schema_seen == '0) flag_fault(ST_SCHEMA);
    end else if (p == POS_EPOCH_END) begin
      epoch_seen = shift_reg;
      if (epoch_seen == '0) flag_fault(ST_EPOCH);
    end else if (p == POS_VALUE_END) begin
      value_seen = shift_reg;
      if (value_seen == '0) flag_fault(ST_VALUE);
    end else if (p == POS_LEN_END) begin
      length_seen = shift_reg[31:0];
    end else if (p == POS_ORIGIN_END) begin
      origin_seen = shift_reg[15:0];
    end else if (p == POS_OP_END) begin
      op_seen = shift_reg[15:0];
    end else if (p == POS_UTC_TAG) begin
      if (b == 8'd1) utc_on = 1'b1;
      else if (b != 8'd0) flag_fault(ST_UTC_TAG);
    end else if (p == POS_UTC_END && utc_on) begin
      utc_secs_seen = shift_reg;
    end

    // the stored crc is skipped by the running crc; everything after it is payload
    if (p >= hlen && p < hlen + CRC_SIZE) begin
      if (p == hlen + CRC_SIZE - 1) crc_stored = shift_reg[31:0];
    end else begin
      crc_acc = crc32_update(crc_acc, b);
      if (p >= hlen + CRC_SIZE) begin
        r = '0;
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        envelope_results.push_back(r);
      end
    end

    if (pos_cnt != '1) pos_cnt = pos_cnt + 1'b1;

    if (fin) begin
      total = p + 1;
      want  = hlen + CRC_SIZE + 64'(length_seen);
      if (total < MIN_TOTAL) st = ST_LENGTH;
      else if (first_fault != ST_OK) st = first_fault;
      else if (total != want) st = ST_LENGTH;
      else if (~crc_acc != crc_stored) st = ST_CRC;
      else st = ST_OK;
      r = '0;
      r.kind             = KIND_SUMMARY;
      r.status           = st;
      r.record_type      = type_seen;
      r.schema_version   = schema_seen;
      r.storage_epoch    = epoch_seen;
      r.version_value    = value_seen;
      r.change_origin    = origin_seen;
      r.change_operation = op_seen;
      r.utc_present      = utc_on;
      r.utc_seconds      = utc_on ? utc_secs_seen : 64'd0;
      r.payload_length   = length_seen;
      envelope_results.push_back(r);
      clear_envelope();
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // result side: every item taken is matched against the oldest one due
  always @(posedge clk) begin : result_check
    rec_result_t due;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (envelope_results.size() == 0) begin
        note_mismatch("result item arrived with none due");
      end else begin
        due = envelope_results.pop_front();
        check_field("kind", 64'(out_if.kind), 64'(due.kind));
        check_field("payload_byte", 64'(out_if.payload_byte), 64'(due.payload_byte));
        check_field("status", 64'(out_if.status), 64'(due.status));
        check_field("record_type", 64'(out_if.record_type), 64'(due.record_type));
        check_field("schema_version", 64'(out_if.schema_version),
                    64'(due.schema_version));
        check_field("storage_epoch", out_if.storage_epoch, due.storage_epoch);
        check_field("version_value", out_if.version_value, due.version_value);
        check_field("change_origin", 64'(out_if.change_origin), 64'(due.change_origin));
        check_field("change_operation", 64'(out_if.change_operation),
                    64'(due.change_operation));
        check_field("utc_present", 64'(out_if.utc_present), 64'(due.utc_present));
        check_field("utc_seconds", out_if.utc_seconds, due.utc_seconds);
        check_field("payload_length", 64'(out_if.payload_length),
                    64'(due.payload_length));
      end
    end
  end

  // receiver: random stall and free-run bursts, a long hold on request, none when quiet
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request <= 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (quiet) begin
      out_if.ready <= 1'b1;
    end else if (rx_burst != 0) begin
      rx_burst = rx_burst - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_if.ready <= 1'b0;
      rx_burst = $urandom_range(1, 12) - 1;
    end else begin
      out_if.ready <= 1'b1;
      rx_burst = $urandom_range(1, 40) - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d result items outstanding", envelope_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!quiet && tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= fin;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    parse_envelope_byte(b, fin);
    bytes_taken++;
  endtask

  task automatic send_record(input int gap_odds);
    tx_gap_odds = gap_odds;
    foreach (rec_bytes[i]) send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (envelope_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_expected_version(input logic [15:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    cfg_if.valid <= 1'b0;
    exp_ver = v;
  endtask

  function automatic int pick_gap_odds();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 2;
      2:       return 5;
      default: return 12;
    endcase
  endfunction

  // random value of w bits, leaning towards the extremes
  function automatic logic [63:0] pick_value(input int w);
    logic [63:0] v;
    logic [63:0] mask;
    mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    case ($urandom_range(0, 7))
      0:       v = 64'd1;
      1:       v = '1;
      2:       v = 64'd1 << (w - 1);
      default: v = {$urandom, $urandom};
    endcase
    return v & mask;
  endfunction

  function automatic env_hdr_t good_header();
    env_hdr_t h;
    h.magic    = MAGIC_WORD;
    h.env_ver  = exp_ver;
    h.rtype    = 16'(pick_value(16));
    h.schema   = 32'(pick_value(32));
    h.epoch    = pick_value(64);
    h.vval     = pick_value(64);
    h.plen     = '0;
    h.origin   = 16'($urandom);
    h.op       = 16'($urandom);
    h.utc_tag  = 8'($urandom_range(0, 1));
    h.utc_secs = pick_value(64);
    return h;
  endfunction

  // header, stored crc, payload; keep > 0 cuts the record, keep < 0 cuts at random
  task automatic make_record(input env_hdr_t h, input int n_pay, input bit crc_bad,
                             input int keep);
    logic [359:0] hv;
    logic [31:0]  acc;
    logic [7:0]   pay[$];
    int           hlen;
    hv   = h;
    acc  = CRC_INIT;
    hlen = (h.utc_tag == 8'd1) ? HDR_BASE + UTC_SIZE : HDR_BASE;
    rec_bytes.delete();
    for (int i = 0; i < hlen; i++) begin
      rec_bytes.push_back(hv[359 - 8*i -: 8]);
      acc = crc32_update(acc, hv[359 - 8*i -: 8]);
    end
    for (int i = 0; i < n_pay; i++) begin
      pay.push_back(8'($urandom));
      acc = crc32_update(acc, pay[i]);
    end
    acc = ~acc;
    if (crc_bad) acc = acc ^ (32'd1 << $urandom_range(0, 31));
    for (int i = 3; i >= 0; i--) rec_bytes.push_back(acc[8*i +: 8]);
    foreach (pay[i]) rec_bytes.push_back(pay[i]);
    if (keep < 0) keep = $urandom_range(1, rec_bytes.size());
    if (keep > 0) while (rec_bytes.size() > keep) void'(rec_bytes.pop_back());
  endtask

  task automatic test_well_formed();
    env_hdr_t h;
    // shortest legal record: no utc field, empty payload
    h = good_header();
    h.utc_tag = 8'd0;
    make_record(h, 0, 1'b0, 0);
    send_record(0);
    h = good_header();
    h.rtype    = '1;
    h.schema   = '1;
    h.epoch    = '1;
    h.vval     = '1;
    h.origin   = '1;
    h.op       = '1;
    h.utc_tag  = 8'd1;
    h.utc_secs = 64'h8000_0000_0000_0000;
    h.plen     = 32'd3;
    make_record(h, 3, 1'b0, 0);
    send_record(pick_gap_odds());
    h = good_header();
    h.rtype    = 16'd1;
    h.schema   = 32'd1;
    h.epoch    = 64'd1;
    h.vval     = 64'd1;
    h.origin   = '0;
    h.op       = '0;
    h.utc_tag  = 8'd1;
    h.utc_secs = '1;
    h.plen     = 32'd5;
    make_record(h, 5, 1'b0, 0);
    send_record(pick_gap_odds());
    wait_drained();
  endtask

  task automatic test_header_checks();
    env_hdr_t h;
    for (int k = 0; k < 7; k++) begin
      h = good_header();
      h.plen = 32'd2;
      case (k)
        0: h.magic   = h.magic ^ 32'h0100_0000;
        1: h.env_ver = ~exp_ver;
        2: h.rtype   = '0;
        3: h.schema  = '0;
        4: h.epoch   = '0;
        5: h.vval    = '0;
        default: h.utc_tag = 8'hFF;
      endcase
      make_record(h, 2, 1'b0, 0);
      send_record(pick_gap_odds());
    end
    // several faults at once: the earliest in stream order wins
    h = good_header();
    h.magic   = 32'h0;
    h.rtype   = '0;
    h.utc_tag = 8'd2;
    h.plen    = 32'd9;
    make_record(h, 1, 1'b1, 0);
    send_record(0);
    h = good_header();
    h.rtype = '0;
    h.vval  = '0;
    make_record(h, 0, 1'b0, 0);
    send_record(0);
    wait_drained();
  endtask

  task automatic test_length_and_crc();
    env_hdr_t h;
    // single byte record
    h = good_header();
    make_record(h, 0, 1'b0, 1);
    send_record(0);
    // one byte short of the minimum, then cut inside the epoch field
    h = good_header();
    h.utc_tag = 8'd0;
    make_record(h, 0, 1'b0, 40);
    send_record(0);
    h = good_header();
    make_record(h, 0, 1'b0, 15);
    send_record(pick_gap_odds());
    // utc field announced but cut before it completes
    h = good_header();
    h.utc_tag = 8'd1;
    make_record(h, 4, 1'b0, 43);
    send_record(0);
    // extra and missing payload bytes
    h = good_header();
    h.plen = 32'd2;
    make_record(h, 4, 1'b0, 0);
    send_record(pick_gap_odds());
    h = good_header();
    h.plen = 32'd4;
    make_record(h, 1, 1'b0, 0);
    send_record(pick_gap_odds());
    h = good_header();
    h.plen = '1;
    make_record(h, 0, 1'b0, 0);
    send_record(0);
    // crc fault alone, then hidden behind a length fault
    h = good_header();
    h.plen = 32'd6;
    make_record(h, 6, 1'b1, 0);
    send_record(pick_gap_odds());
    h = good_header();
    h.plen = 32'd1;
    make_record(h, 3, 1'b1, 0);
    send_record(0);
    wait_drained();
  endtask

  task automatic test_expected_version();
    env_hdr_t h;
    write_expected_version(16'h0000);
    h = good_header();
    h.plen = 32'd1;
    make_record(h, 1, 1'b0, 0);
    send_record(0);
    h = good_header();
    h.env_ver = 16'd1;
    make_record(h, 0, 1'b0, 0);
    send_record(0);
    wait_drained();
    write_expected_version(16'hFFFF);
    h = good_header();
    h.plen = 32'd2;
    make_record(h, 2, 1'b0, 0);
    send_record(pick_gap_odds());
    wait_drained();
    write_expected_version(EXP_VER_RESET);
  endtask

  // receiver holds off while a long record streams in, so the input must stall
  task automatic test_receiver_hold();
    env_hdr_t h;
    h = good_header();
    h.plen = 32'd40;
    make_record(h, 40, 1'b0, 0);
    hold_request <= 200;
    send_record(0);
    h = good_header();
    h.plen = 32'd8;
    make_record(h, 8, 1'b0, 0);
    send_record(0);
    wait_drained();
  endtask

  task automatic random_record();
    env_hdr_t h;
    int       n_pay;
    bit       crc_bad;
    int       keep;
    n_pay   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
    h       = good_header();
    h.plen  = 32'(n_pay);
    crc_bad = 1'b0;
    keep    = 0;
    case ($urandom_range(0, 31))
      0:  h.magic   = h.magic ^ (32'd1 << $urandom_range(0, 31));
      1:  h.env_ver = exp_ver ^ (16'd1 << $urandom_range(0, 15));
      2:  h.rtype   = '0;
      3:  h.schema  = '0;
      4:  h.epoch   = '0;
      5:  h.vval    = '0;
      6:  h.utc_tag = 8'($urandom_range(2, 255));
      7:  h.plen    = h.plen + 32'($urandom_range(1, 3));
      8:  h.plen    = (n_pay > 0) ? h.plen - 32'd1 : 32'($urandom);
      9:  crc_bad   = 1'b1;
      10: keep      = $urandom_range(1, 40);
      11: keep      = -1;
      12: begin
        // line noise: random bytes ending in a last flag
        rec_bytes.delete();
        repeat ($urandom_range(1, 60)) rec_bytes.push_back(8'($urandom));
        keep = -2;
      end
      13: begin
        h.magic = h.magic ^ 32'h0000_0080;
        h.vval  = '0;
        h.plen  = h.plen + 32'd1;
        crc_bad = 1'b1;
      end
      default: ;
    endcase
    if (keep != -2) make_record(h, n_pay, crc_bad, keep);
    send_record(quiet ? 0 : pick_gap_odds());
  endtask

  function automatic logic [15:0] pick_version();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return EXP_VER_RESET;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_random_records();
    int start;
    int recs;
    start = bytes_taken;
    recs  = 0;
    while (bytes_taken - start < RANDOM_ITEMS) begin
      if (bytes_taken - start >= RANDOM_ITEMS - 200) quiet = 1'b1;
      if (recs % 10 == 9 && !quiet) begin
        wait_drained();
        write_expected_version(pick_version());
      end
      random_record();
      recs++;
    end
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    out_if.ready    = 1'b0;
    clear_envelope();
    exp_ver = EXP_VER_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_well_formed();
    test_header_checks();
    test_length_and_crc();
    test_expected_version();
    test_receiver_hold();
    test_random_records();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
